[design/tpc_pkg.sv]
// Shared types, widths and register codes for the touch point calibrator.
`default_nettype none

package tpc_pkg;

    // Datapath width of one axis: raw samples and screen coordinates up to 4095.
    localparam int AXIS_W = 12;
    localparam int PROD_W = 2 * AXIS_W;

    localparam int POSX_W = 8;
    localparam int POSY_W = 9;
    localparam int CALX_W = 8;
    localparam int CALY_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [AXIS_W-1:0] RST_PRESS_THR = 12'd80;
    localparam logic [AXIS_W-1:0] RST_RAW_LOW   = 12'd200;
    localparam logic [AXIS_W-1:0] RST_RAW_HIGH  = 12'd3900;
    localparam logic [CALX_W-1:0] RST_CAL_X_LOW  = 8'd11;
    localparam logic [CALX_W-1:0] RST_CAL_X_HIGH = 8'd220;
    localparam logic [CALY_W-1:0] RST_CAL_Y_HIGH = 9'd319;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_THR  = 3'd0,
        REG_RAW_X_LOW  = 3'd1,
        REG_RAW_X_HIGH = 3'd2,
        REG_RAW_Y_LOW  = 3'd3,
        REG_RAW_Y_HIGH = 3'd4,
        REG_CAL_X_LOW  = 3'd5,
        REG_CAL_X_HIGH = 3'd6,
        REG_CAL_Y_HIGH = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [AXIS_W-1:0] press_thr;
        logic [AXIS_W-1:0] raw_x_low;
        logic [AXIS_W-1:0] raw_x_high;
        logic [AXIS_W-1:0] raw_y_low;
        logic [AXIS_W-1:0] raw_y_high;
        logic [CALX_W-1:0] cal_x_low;
        logic [CALX_W-1:0] cal_x_high;
        logic [CALY_W-1:0] cal_y_high;
    } cfg_t;

    // Status of one axis engine towards the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } axis_stat_t;

endpackage

`default_nettype wire

[design/tpc_cfg_regs.sv]
// Configuration register file of the touch point calibrator.
`default_nettype none

module tpc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output tpc_pkg::cfg_t                       cfg
);
    import tpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PRESS_THR:  cfg_next.press_thr  = cfg_data[AXIS_W-1:0];
                REG_RAW_X_LOW:  cfg_next.raw_x_low  = cfg_data[AXIS_W-1:0];
                REG_RAW_X_HIGH: cfg_next.raw_x_high = cfg_data[AXIS_W-1:0];
                REG_RAW_Y_LOW:  cfg_next.raw_y_low  = cfg_data[AXIS_W-1:0];
                REG_RAW_Y_HIGH: cfg_next.raw_y_high = cfg_data[AXIS_W-1:0];
                REG_CAL_X_LOW:  cfg_next.cal_x_low  = cfg_data[CALX_W-1:0];
                REG_CAL_X_HIGH: cfg_next.cal_x_high = cfg_data[CALX_W-1:0];
                REG_CAL_Y_HIGH: cfg_next.cal_y_high = cfg_data[CALY_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_thr  <= RST_PRESS_THR;
            cfg_reg.raw_x_low  <= RST_RAW_LOW;
            cfg_reg.raw_x_high <= RST_RAW_HIGH;
            cfg_reg.raw_y_low  <= RST_RAW_LOW;
            cfg_reg.raw_y_high <= RST_RAW_HIGH;
            cfg_reg.cal_x_low  <= RST_CAL_X_LOW;
            cfg_reg.cal_x_high <= RST_CAL_X_HIGH;
            cfg_reg.cal_y_high <= RST_CAL_Y_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/tpc_sdiv.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module tpc_sdiv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tpc_pkg::PROD_W-1:0]  dividend,
    input  wire logic [tpc_pkg::AXIS_W-1:0]  divisor,
    output logic                             done,
    output logic [tpc_pkg::AXIS_W-1:0]       quotient
);
    import tpc_pkg::*;

    localparam int CNT_W = $clog2(AXIS_W + 1);

    logic [AXIS_W-1:0] rem_reg, rem_next;
    logic [AXIS_W-1:0] quo_reg, quo_next;
    logic [AXIS_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [AXIS_W:0]   trial;

    // Caller guarantees dividend[hi] < divisor, so the quotient fits AXIS_W bits
    // and the partial remainder always stays below the divisor.
    assign trial = {rem_reg, quo_reg[AXIS_W-1]} - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend[PROD_W-1:AXIS_W];
            quo_next = dividend[AXIS_W-1:0];
            div_next = divisor;
            cnt_next = CNT_W'(AXIS_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[AXIS_W])
            begin
                rem_next = trial[AXIS_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[AXIS_W-2:0], quo_reg[AXIS_W-1]};
            end
            quo_next  = {quo_reg[AXIS_W-2:0], ~trial[AXIS_W]};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[design/tpc_axis.sv]
// One axis: raw window map, inversion and calibration window map.
`default_nettype none

module tpc_axis #(
    parameter int SIZE = 240
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tpc_pkg::AXIS_W-1:0]  raw,
    input  wire logic [tpc_pkg::AXIS_W-1:0]  raw_low,
    input  wire logic [tpc_pkg::AXIS_W-1:0]  raw_high,
    input  wire logic [tpc_pkg::AXIS_W-1:0]  cal_low,
    input  wire logic [tpc_pkg::AXIS_W-1:0]  cal_high,
    output tpc_pkg::axis_stat_t              stat,
    output logic [tpc_pkg::AXIS_W-1:0]       result
);
    import tpc_pkg::*;

    localparam logic [AXIS_W-1:0] TOP = AXIS_W'(SIZE - 1);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_EVAL = 4'b0010,
        A_WAIT = 4'b0100,
        A_DONE = 4'b1000
    } axis_state_t;

    axis_state_t       state_reg, state_next;
    logic              stage_reg, stage_next;   // 0: raw window, 1: calibration window
    logic [AXIS_W-1:0] v_reg, v_next;
    logic [AXIS_W-1:0] res_reg, res_next;

    logic [AXIS_W-1:0] cur_low, cur_high, diff, map_val;
    logic [PROD_W-1:0] prod;
    logic              win_bad, below, above, map_ready, div_start, div_done;
    logic [AXIS_W-1:0] div_quo;

    assign cur_low  = stage_reg ? cal_low  : raw_low;
    assign cur_high = stage_reg ? cal_high : raw_high;
    assign win_bad  = (raw_high <= raw_low) || (cal_high <= cal_low);
    assign below    = (v_reg <= cur_low);
    assign above    = (v_reg >= cur_high);
    assign diff     = v_reg - cur_low;
    assign prod     = PROD_W'(diff) * PROD_W'(TOP);

    assign div_start = (state_reg == A_EVAL) && !win_bad && !below && !above;

    tpc_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (cur_high - cur_low),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        map_ready = 1'b0;
        map_val   = '0;
        case (state_reg)
            A_EVAL:
            begin
                map_ready = below || above;
                map_val   = below ? '0 : TOP;
            end
            A_WAIT:
            begin
                map_ready = div_done;
                map_val   = div_quo;
            end
            default:
            begin
                map_ready = 1'b0;
                map_val   = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        if (start)
        begin
            state_next = A_EVAL;
            stage_next = 1'b0;
            v_next     = raw;
        end
        else if ((state_reg == A_EVAL) && win_bad)
        begin
            res_next   = '0;
            state_next = A_DONE;
        end
        else if (map_ready)
        begin
            if (!stage_reg)
            begin
                v_next     = TOP - map_val;
                stage_next = 1'b1;
                state_next = A_EVAL;
            end
            else
            begin
                res_next   = map_val;
                state_next = A_DONE;
            end
        end
        else if (div_start)
        begin
            state_next = A_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            stage_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign stat.busy = (state_reg == A_EVAL) || (state_reg == A_WAIT);
    assign stat.done = (state_reg == A_DONE);
    assign result    = res_reg;

endmodule

`default_nettype wire

[design/touch_point_calibrator.sv]
// Top level of the two-point touch calibrator: sequencer, held point, result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------
//  item     | item_valid / item_ready   | raw_x[11:0], raw_y[11:0]
//  result   | result_valid/result_ready | pos_x[7:0], pos_y[8:0], pressed
//  cfg      | cfg_valid / cfg_ready     | cfg_index[2:0], cfg_data[11:0]
//
// A pressed word starts both axes as it is accepted. When its maps both divide, each axis
// does two window maps (evaluate, load, 12 divide steps), both axes side by side, and
// then the result register is loaded. A clamped or collapsed window skips its divide.
// A released word needs no axis work. item_ready is high only in T_IDLE, which is entered
// as a result is registered, so no new word is taken while one is still in its run.
// The result register lets the next word in while a result waits; that word then stalls
// at its end until the waiting result is taken.
// Reset is asynchronous: held point to zero, configuration registers to their defaults.
`default_nettype none

module touch_point_calibrator #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [tpc_pkg::AXIS_W-1:0]     raw_x,
    input  wire logic [tpc_pkg::AXIS_W-1:0]     raw_y,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic [tpc_pkg::POSX_W-1:0]          pos_x,
    output logic [tpc_pkg::POSY_W-1:0]          pos_y,
    output logic                                pressed,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tpc_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_RUN  = 2'b10
    } top_state_t;

    top_state_t        state_reg, state_next;
    logic              press_reg, press_next;
    logic              rv_reg, rv_next;
    logic [POSX_W-1:0] held_x_reg, held_x_next, pos_x_reg, pos_x_next;
    logic [POSY_W-1:0] held_y_reg, held_y_next, pos_y_reg, pos_y_next;
    logic              pressed_reg, pressed_next;

    cfg_t              cfg;
    axis_stat_t        x_stat, y_stat;
    logic [AXIS_W-1:0] x_res, y_res;
    logic              accept, press_now, axis_start, fin;

    assign cfg_ready = 1'b1;

    tpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign item_ready = (state_reg == T_IDLE);
    assign accept     = item_valid && item_ready;
    assign press_now  = (raw_x >= cfg.press_thr) && (raw_y >= cfg.press_thr);
    assign axis_start = accept && press_now;

    tpc_axis #(.SIZE(SCREEN_WIDTH)) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (axis_start),
        .raw      (raw_x),
        .raw_low  (cfg.raw_x_low),
        .raw_high (cfg.raw_x_high),
        .cal_low  (AXIS_W'(cfg.cal_x_low)),
        .cal_high (AXIS_W'(cfg.cal_x_high)),
        .stat     (x_stat),
        .result   (x_res)
    );

    // Low end of the y calibration window is tied to zero.
    tpc_axis #(.SIZE(SCREEN_HEIGHT)) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (axis_start),
        .raw      (raw_y),
        .raw_low  (cfg.raw_y_low),
        .raw_high (cfg.raw_y_high),
        .cal_low  ('0),
        .cal_high (AXIS_W'(cfg.cal_y_high)),
        .stat     (y_stat),
        .result   (y_res)
    );

    assign fin = (state_reg == T_RUN)
              && (!press_reg || (x_stat.done && y_stat.done))
              && (!rv_reg || result_ready);

    always_comb
    begin
        state_next   = state_reg;
        press_next   = press_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        pressed_next = pressed_reg;
        rv_next      = rv_reg && !result_ready;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    press_next = press_now;
                    state_next = T_RUN;
                end
            end
            T_RUN:
            begin
                if (fin)
                begin
                    rv_next      = 1'b1;
                    pressed_next = press_reg;
                    state_next   = T_IDLE;
                    if (press_reg)
                    begin
                        held_x_next = x_res[POSX_W-1:0];
                        held_y_next = y_res[POSY_W-1:0];
                        pos_x_next  = x_res[POSX_W-1:0];
                        pos_y_next  = y_res[POSY_W-1:0];
                    end
                    else
                    begin
                        pos_x_next = held_x_reg;
                        pos_y_next = held_y_reg;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            press_reg  <= 1'b0;
            rv_reg     <= 1'b0;
            held_x_reg <= '0;
            held_y_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            press_reg  <= press_next;
            rv_reg     <= rv_next;
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        pressed_reg <= pressed_next;
    end

    assign result_valid = rv_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pressed      = pressed_reg;

    // A waiting result always shows the held point.
    a_result_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pos_x == held_x_reg) && (pos_y == held_y_reg))
        else $error("result word differs from held point");

    // Axes are only kicked when idle or finished.
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        axis_start |-> !x_stat.busy && !y_stat.busy)
        else $error("axis started while busy");

    // A new result only appears at the end of a run.
    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == T_RUN))
        else $error("result raised outside a run");

endmodule

`default_nettype wire

[dv/touch_point_calibrator_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for touch_point_calibrator: directed table, then random phases.
module touch_point_calibrator_tb;
    import tpc_pkg::*;

    localparam int SCREEN_W        = 240;
    localparam int SCREEN_H        = 320;
    localparam int NUM_REGS        = 8;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic [POSX_W-1:0] pos_x;
        logic [POSY_W-1:0] pos_y;
        logic              pressed;
    } touch_pt_t;

    typedef enum logic [1:0] {ROW_TOUCH, ROW_KNOWN, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [AXIS_W-1:0]     x;
        logic [AXIS_W-1:0]     y;
        touch_pt_t             known;
        reg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
    } stim_row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    logic [AXIS_W-1:0]     raw_x        = '0;
    logic [AXIS_W-1:0]     raw_y        = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [POSX_W-1:0]     pos_x;
    logic [POSY_W-1:0]     pos_y;
    logic                  pressed;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // known expectation travels with the word it belongs to
    logic                  touch_known    = 1'b0;
    touch_pt_t             touch_known_pt = '0;

    cfg_t                  cfg_shadow;
    logic [POSX_W-1:0]     held_x = '0;
    logic [POSY_W-1:0]     held_y = '0;
    touch_pt_t             pending_pts[$];
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;
    int                    stall_left     = 0;
    logic                  quiet          = 1'b0;

    touch_point_calibrator #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pressed      (pressed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // linear map of v over lo..hi onto 0..top, clamped both ends
    function automatic int unsigned span_map(input int unsigned v, lo, hi, top);
        int unsigned r;
        if (v <= lo)
            return 0;
        if (v >= hi)
            return top;
        r = ((v - lo) * top) / (hi - lo);
        return (r > top) ? top : r;
    endfunction

    function automatic int unsigned calib_axis(input int unsigned raw, rlo, rhi, clo, chi,
                                               size);
        int unsigned top;
        top = size - 1;
        if (rhi <= rlo || chi <= clo)
            return 0;
        return span_map(top - span_map(raw, rlo, rhi, top), clo, chi, top);
    endfunction

    // returns the expected word and updates the held point on a press
    function automatic touch_pt_t calibrate_touch(input logic [AXIS_W-1:0] rx, ry);
        touch_pt_t pt;
        pt.pressed = (rx >= cfg_shadow.press_thr) && (ry >= cfg_shadow.press_thr);
        if (pt.pressed)
        begin
            held_x = POSX_W'(calib_axis(rx, cfg_shadow.raw_x_low, cfg_shadow.raw_x_high,
                                        cfg_shadow.cal_x_low, cfg_shadow.cal_x_high,
                                        SCREEN_W));
            held_y = POSY_W'(calib_axis(ry, cfg_shadow.raw_y_low, cfg_shadow.raw_y_high,
                                        0, cfg_shadow.cal_y_high, SCREEN_H));
        end
        pt.pos_x = held_x;
        pt.pos_y = held_y;
        return pt;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [AXIS_W-1:0] pick_raw(input logic [AXIS_W-1:0] thr, lo, hi);
        case ($urandom_range(0, 9))
            0:       return (thr == 0) ? '0 : AXIS_W'($urandom_range(0, thr - 1));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            2, 3, 4: return AXIS_W'($urandom_range(lo, hi));
            default: return AXIS_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic stim_row_t touch_row(input logic [AXIS_W-1:0] x, y);
        return '{ROW_TOUCH, x, y, '0, REG_PRESS_THR, '0};
    endfunction

    function automatic stim_row_t known_row(input logic [AXIS_W-1:0] x, y,
                                           input logic [POSX_W-1:0] px,
                                           input logic [POSY_W-1:0] py, input logic pr);
        return '{ROW_KNOWN, x, y, '{px, py, pr}, REG_PRESS_THR, '0};
    endfunction

    function automatic stim_row_t reg_row(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        return '{ROW_REG, '0, '0, '0, idx, d};
    endfunction

    task automatic send_touch(input logic [AXIS_W-1:0] x, y, input logic known,
                              input touch_pt_t pt);
        int gap;
        gap = pick_gap();
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid     <= 1'b1;
        raw_x          <= x;
        raw_y          <= y;
        touch_known    <= known;
        touch_known_pt <= pt;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        item_valid <= 1'b0;
        while (pending_pts.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        touch_pt_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_PRESS_THR:  cfg_shadow.press_thr  = cfg_data;
                    REG_RAW_X_LOW:  cfg_shadow.raw_x_low  = cfg_data;
                    REG_RAW_X_HIGH: cfg_shadow.raw_x_high = cfg_data;
                    REG_RAW_Y_LOW:  cfg_shadow.raw_y_low  = cfg_data;
                    REG_RAW_Y_HIGH: cfg_shadow.raw_y_high = cfg_data;
                    REG_CAL_X_LOW:  cfg_shadow.cal_x_low  = cfg_data[CALX_W-1:0];
                    REG_CAL_X_HIGH: cfg_shadow.cal_x_high = cfg_data[CALX_W-1:0];
                    REG_CAL_Y_HIGH: cfg_shadow.cal_y_high = cfg_data[CALY_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                want = calibrate_touch(raw_x, raw_y);
                if (touch_known)
                    want = touch_known_pt;
                pending_pts.push_back(want);
            end
            if (result_valid && result_ready)
            begin
                if (pending_pts.size() == 0)
                begin
                    $error("unexpected word: pos_x %0d pos_y %0d pressed %0d",
                           pos_x, pos_y, pressed);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_pts.pop_front();
                    if (pos_x !== want.pos_x)
                    begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, pos_x);
                        mismatch_count++;
                    end
                    if (pos_y !== want.pos_y)
                    begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, pos_y);
                        mismatch_count++;
                    end
                    if (pressed !== want.pressed)
                    begin
                        $error("pressed: expected %0d, got %0d", want.pressed, pressed);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // stretches with no gaps on either side
    initial
    begin
        forever
        begin
            repeat ($urandom_range(40, 250)) @(negedge clk);
            quiet <= ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        stim_row_t             rows[$];
        logic [CFG_DATA_W-1:0] setting [NUM_REGS];
        logic [AXIS_W-1:0]     rx;
        logic [AXIS_W-1:0]     ry;

        cfg_shadow.press_thr  = RST_PRESS_THR;
        cfg_shadow.raw_x_low  = RST_RAW_LOW;
        cfg_shadow.raw_x_high = RST_RAW_HIGH;
        cfg_shadow.raw_y_low  = RST_RAW_LOW;
        cfg_shadow.raw_y_high = RST_RAW_HIGH;
        cfg_shadow.cal_x_low  = RST_CAL_X_LOW;
        cfg_shadow.cal_x_high = RST_CAL_X_HIGH;
        cfg_shadow.cal_y_high = RST_CAL_Y_HIGH;

        // reset settings, held point starts at zero
        rows.push_back(known_row(12'd0,    12'd0,    8'd0,   9'd0,   1'b0));
        rows.push_back(known_row(12'd4095, 12'd4095, 8'd0,   9'd0,   1'b1));
        rows.push_back(known_row(12'd200,  12'd200,  8'd239, 9'd319, 1'b1));
        rows.push_back(known_row(12'd0,    12'd4095, 8'd239, 9'd319, 1'b0));
        rows.push_back(known_row(12'd4095, 12'd79,   8'd239, 9'd319, 1'b0));
        rows.push_back(known_row(12'd80,   12'd80,   8'd239, 9'd319, 1'b1));
        rows.push_back(known_row(12'd79,   12'd4095, 8'd239, 9'd319, 1'b0));
        rows.push_back(known_row(12'd3900, 12'd3900, 8'd0,   9'd0,   1'b1));
        rows.push_back(touch_row(12'd2048, 12'd2048));
        rows.push_back(touch_row(12'd201,  12'd3899));
        rows.push_back(touch_row(12'hAAA,  12'h555));
        rows.push_back(touch_row(12'h555,  12'hAAA));
        rows.push_back(touch_row(12'd1234, 12'd2345));
        // collapsed x raw window
        rows.push_back(reg_row(REG_RAW_X_HIGH, 12'd100));
        rows.push_back(known_row(12'd2000, 12'd200,  8'd0,   9'd319, 1'b1));
        // collapsed y calibration window
        rows.push_back(reg_row(REG_CAL_Y_HIGH, 12'd0));
        rows.push_back(known_row(12'd2000, 12'd2000, 8'd0,   9'd0,   1'b1));
        // calibration highs beyond the screen, threshold off
        rows.push_back(reg_row(REG_RAW_X_HIGH, 12'd4095));
        rows.push_back(reg_row(REG_CAL_X_LOW,  12'd0));
        rows.push_back(reg_row(REG_CAL_X_HIGH, 12'hFFF));
        rows.push_back(reg_row(REG_CAL_Y_HIGH, 12'hFFF));
        rows.push_back(reg_row(REG_PRESS_THR,  12'd0));
        rows.push_back(touch_row(12'd0,    12'd0));
        rows.push_back(touch_row(12'd4095, 12'd4095));
        rows.push_back(touch_row(12'd3000, 12'd1000));
        // equal lows and highs on both axes
        rows.push_back(reg_row(REG_CAL_X_LOW,  12'd239));
        rows.push_back(reg_row(REG_CAL_X_HIGH, 12'd239));
        rows.push_back(reg_row(REG_RAW_Y_LOW,  12'd4095));
        rows.push_back(reg_row(REG_RAW_Y_HIGH, 12'd4095));
        rows.push_back(known_row(12'd3000, 12'd3000, 8'd0,   9'd0,   1'b1));
        rows.push_back(reg_row(REG_PRESS_THR,  12'd4095));
        rows.push_back(known_row(12'd4094, 12'd4095, 8'd0,   9'd0,   1'b0));
        rows.push_back(known_row(12'd4095, 12'd4095, 8'd0,   9'd0,   1'b1));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_REG:   write_reg(rows[i].idx, rows[i].data);
                ROW_KNOWN: send_touch(rows[i].x, rows[i].y, 1'b1, rows[i].known);
                default:   send_touch(rows[i].x, rows[i].y, 1'b0, rows[i].known);
            endcase
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: setting = '{RST_PRESS_THR, RST_RAW_LOW, RST_RAW_HIGH, RST_RAW_LOW,
                               RST_RAW_HIGH, CFG_DATA_W'(RST_CAL_X_LOW),
                               CFG_DATA_W'(RST_CAL_X_HIGH), CFG_DATA_W'(RST_CAL_Y_HIGH)};
                1: setting = '{default: '0};
                2: setting = '{default: '1};
                4:
                begin
                    foreach (setting[i])
                        setting[i] = CFG_DATA_W'($urandom_range(0, 4095));
                end
                5: setting = '{12'd1, 12'd2000, 12'd2001, 12'd0, 12'd4095,
                               12'd238, 12'd239, 12'd1};
                default:
                begin
                    setting[REG_PRESS_THR]  = CFG_DATA_W'($urandom_range(0, 300));
                    setting[REG_RAW_X_LOW]  = CFG_DATA_W'($urandom_range(0, 1500));
                    setting[REG_RAW_X_HIGH] = CFG_DATA_W'($urandom_range(2500, 4095));
                    setting[REG_RAW_Y_LOW]  = CFG_DATA_W'($urandom_range(0, 1500));
                    setting[REG_RAW_Y_HIGH] = CFG_DATA_W'($urandom_range(2500, 4095));
                    setting[REG_CAL_X_LOW]  = CFG_DATA_W'($urandom_range(0, 60));
                    setting[REG_CAL_X_HIGH] = CFG_DATA_W'($urandom_range(180, 239));
                    setting[REG_CAL_Y_HIGH] = CFG_DATA_W'($urandom_range(200, 319));
                end
            endcase
            for (int i = 0; i < NUM_REGS; i++)
                write_reg(reg_idx_t'(i), setting[i]);
            repeat (ITEMS_PER_PHASE)
            begin
                rx = pick_raw(setting[REG_PRESS_THR], setting[REG_RAW_X_LOW],
                              setting[REG_RAW_X_HIGH]);
                ry = pick_raw(setting[REG_PRESS_THR], setting[REG_RAW_Y_LOW],
                              setting[REG_RAW_Y_HIGH]);
                send_touch(rx, ry, 1'b0, '0);
            end
        end

        item_valid <= 1'b0;
        cfg_valid  <= 1'b0;
        while (pending_pts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
